### rtl/core/spt_pkg.sv
`default_nettype none

package spt_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 1'b1;

	localparam logic [15:0] MAX_WIDTH_RST = 16'd1024;
	localparam logic [15:0] MAX_COUNT_RST = 16'd1000;

	localparam logic [7:0] OP_PUSH_FIRST = 8'h01;
	localparam logic [7:0] OP_PUSH_LAST  = 8'h4b;
	localparam logic [7:0] OP_LEN1_PUSH  = 8'h4c;
	localparam logic [7:0] OP_LEN2_PUSH  = 8'h4d;
	localparam logic [7:0] OP_LEN4_PUSH  = 8'h4e;

	typedef enum logic [4:0] {
		PH_OPCODE  = 5'b00001,
		PH_LEN1    = 5'b00010,
		PH_LEN2_LO = 5'b00100,
		PH_LEN2_HI = 5'b01000,
		PH_DATA    = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OP    = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_PD4   = 3'd1,
		ERR_TRUNC = 3'd2,
		ERR_WIDE  = 3'd3,
		ERR_COUNT = 3'd4
	} err_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] bytes_left;
		logic [15:0] cur_width;
		logic [7:0]  len_low;
		logic [15:0] frame_cnt;
		logic        err_latched;
		err_t        err_code;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [15:0] width;
		logic [15:0] number;
		logic        frame_end;
		err_t        code;
		logic        done;
	} tok_t;

	localparam state_t ST_RESET = '{
		phase:       PH_OPCODE,
		bytes_left:  16'd0,
		cur_width:   16'd0,
		len_low:     8'd0,
		frame_cnt:   16'd0,
		err_latched: 1'b0,
		err_code:    ERR_NONE
	};

endpackage

`default_nettype wire

### rtl/core/spt_step.sv
`default_nettype none

module spt_step (
	input  spt_pkg::state_t st,
	input  logic [15:0]     max_width,
	input  logic [15:0]     max_count,
	input  logic [7:0]      in_byte,
	input  logic            eop,
	output spt_pkg::state_t nxt,
	output logic            emit,
	output spt_pkg::tok_t   tok
);

	logic            raise;
	spt_pkg::err_t   rcode;
	logic            push;
	logic [15:0]     pw;

	always_comb begin
		nxt   = st;
		emit  = 1'b0;
		tok   = '{kind: spt_pkg::KIND_OP, value: 8'd0, width: 16'd0, number: st.frame_cnt,
			frame_end: 1'b0, code: spt_pkg::ERR_NONE, done: eop};
		raise = 1'b0;
		rcode = spt_pkg::ERR_NONE;
		push  = 1'b0;
		pw    = {8'h00, in_byte};

		if (st.err_latched) begin
			if (eop) begin
				emit     = 1'b1;
				tok.kind = spt_pkg::KIND_ERR;
				tok.code = st.err_code;
			end
		end else begin
			unique case (st.phase)
				spt_pkg::PH_OPCODE: begin
					priority if (st.frame_cnt >= max_count) begin
						raise = 1'b1;
						rcode = spt_pkg::ERR_COUNT;
					end else if (in_byte >= spt_pkg::OP_PUSH_FIRST &&
							in_byte <= spt_pkg::OP_PUSH_LAST) begin
						push = 1'b1;
					end else if (in_byte == spt_pkg::OP_LEN1_PUSH ||
							in_byte == spt_pkg::OP_LEN2_PUSH) begin
						if (eop) begin
							raise = 1'b1;
							rcode = spt_pkg::ERR_TRUNC;
						end else if (in_byte == spt_pkg::OP_LEN1_PUSH) begin
							nxt.phase = spt_pkg::PH_LEN1;
						end else begin
							nxt.phase = spt_pkg::PH_LEN2_LO;
						end
					end else if (in_byte == spt_pkg::OP_LEN4_PUSH) begin
						raise = 1'b1;
						rcode = spt_pkg::ERR_PD4;
					end else begin
						emit          = 1'b1;
						tok.kind      = spt_pkg::KIND_OP;
						tok.value     = in_byte;
						tok.width     = 16'd1;
						tok.frame_end = 1'b1;
						nxt.frame_cnt = st.frame_cnt + 16'd1;
					end
				end
				spt_pkg::PH_LEN1: begin
					push = 1'b1;
				end
				spt_pkg::PH_LEN2_LO: begin
					if (eop) begin
						raise = 1'b1;
						rcode = spt_pkg::ERR_TRUNC;
					end else begin
						nxt.len_low = in_byte;
						nxt.phase   = spt_pkg::PH_LEN2_HI;
					end
				end
				spt_pkg::PH_LEN2_HI: begin
					push = 1'b1;
					pw   = {in_byte, st.len_low};
				end
				spt_pkg::PH_DATA: begin
					emit      = 1'b1;
					tok.kind  = spt_pkg::KIND_DATA;
					tok.value = in_byte;
					tok.width = st.cur_width;
					if (st.bytes_left <= 16'd1) begin
						tok.frame_end  = 1'b1;
						nxt.bytes_left = 16'd0;
						nxt.frame_cnt  = st.frame_cnt + 16'd1;
						nxt.phase      = spt_pkg::PH_OPCODE;
					end else if (eop) begin
						raise = 1'b1;
						rcode = spt_pkg::ERR_TRUNC;
					end else begin
						nxt.bytes_left = st.bytes_left - 16'd1;
					end
				end
				default: begin
					nxt.phase = spt_pkg::PH_OPCODE;
				end
			endcase

			if (push) begin
				priority if (pw == 16'd0) begin
					emit          = 1'b1;
					tok.kind      = spt_pkg::KIND_EMPTY;
					tok.frame_end = 1'b1;
					nxt.frame_cnt = st.frame_cnt + 16'd1;
					nxt.phase     = spt_pkg::PH_OPCODE;
				end else if (pw > max_width) begin
					raise = 1'b1;
					rcode = spt_pkg::ERR_WIDE;
				end else if (eop) begin
					raise = 1'b1;
					rcode = spt_pkg::ERR_TRUNC;
				end else begin
					nxt.cur_width  = pw;
					nxt.bytes_left = pw;
					nxt.phase      = spt_pkg::PH_DATA;
				end
			end

			if (raise) begin
				emit            = 1'b1;
				tok.kind        = spt_pkg::KIND_ERR;
				tok.value       = 8'd0;
				tok.width       = 16'd0;
				tok.frame_end   = 1'b0;
				tok.code        = rcode;
				nxt.err_latched = 1'b1;
				nxt.err_code    = rcode;
			end
		end

		// final byte always closes the program
		if (eop) begin
			nxt = spt_pkg::ST_RESET;
		end
	end

endmodule

`default_nettype wire

### rtl/core/script_pushdata_tokenizer_top.sv
// Script push-data tokenizer.
// Input channel (in_valid/in_ready): one script byte per transfer, with
// end_of_program set on the final byte of a program. Output channel
// (out_valid/out_ready): at most one token per input byte: opcode, data
// byte, empty push or error, tagged with frame number and width.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 max_frame_width, 1 max_frame_count); write only while idle.
// A byte taken on the input is held in the byte register and is then decoded
// into the output register when the tokenizer advances; a stall can delay it.
// Throughput: one byte per cycle while the receiver does not stall; the byte
// register, the tokenizer state and the output register advance together.
// A stalled receiver holds the output register; the byte register then
// fills and in_ready drops until the token is taken.
// Reset: limits return to 1024 and 1000, the tokenizer returns to the
// opcode phase with frame count zero and no error, and both stages empty.
`default_nettype none

module script_pushdata_tokenizer_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [spt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       script_byte,
	input  wire logic                             end_of_program,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [1:0]                            token_kind,
	output logic [7:0]                            token_value,
	output logic [15:0]                           frame_width,
	output logic [15:0]                           frame_number,
	output logic                                  frame_end,
	output logic [2:0]                            error_code,
	output logic                                  program_done
);

	logic [15:0]     max_width_q;
	logic [15:0]     max_count_q;
	spt_pkg::state_t st_q;
	spt_pkg::state_t st_nxt;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eop_s1;
	logic            out_valid_q;
	spt_pkg::tok_t   tok_q;
	spt_pkg::tok_t   tok_nxt;
	logic            emit;
	logic            adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= spt_pkg::MAX_WIDTH_RST;
			max_count_q <= spt_pkg::MAX_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spt_pkg::REG_MAX_WIDTH: max_width_q <= cfg_data;
				spt_pkg::REG_MAX_COUNT: max_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= script_byte;
			eop_s1  <= end_of_program;
		end
	end

	spt_step u_step (
		.st        (st_q),
		.max_width (max_width_q),
		.max_count (max_count_q),
		.in_byte   (byte_s1),
		.eop       (eop_s1),
		.nxt       (st_nxt),
		.emit      (emit),
		.tok       (tok_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= spt_pkg::ST_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= st_nxt;
			end
			if (adv) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			tok_q <= tok_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign token_kind   = tok_q.kind;
	assign token_value  = tok_q.value;
	assign frame_width  = tok_q.width;
	assign frame_number = tok_q.number;
	assign frame_end    = tok_q.frame_end;
	assign error_code   = tok_q.code;
	assign program_done = tok_q.done;

	a_err_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tok_q.kind == spt_pkg::KIND_ERR |-> tok_q.code != spt_pkg::ERR_NONE)
		else $error("error token without code");

	a_ok_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tok_q.kind != spt_pkg::KIND_ERR |-> tok_q.code == spt_pkg::ERR_NONE)
		else $error("code on non-error token");

	a_op_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tok_q.kind == spt_pkg::KIND_OP |-> tok_q.width == 16'd1 && tok_q.frame_end)
		else $error("opcode token malformed");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eop_s1 |=> st_q.frame_cnt == 16'd0 && !st_q.err_latched &&
			st_q.phase == spt_pkg::PH_OPCODE)
		else $error("state not cleared after final byte");

	a_eop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eop_s1 |=> out_valid_q && tok_q.done)
		else $error("final byte gave no closing token");

endmodule

`default_nettype wire
